// ----- hw/rtl/sorted_priority_queue_top_assert.svh -----
// assertion macros for the sorted priority queue top level
// expects clk and rst_n in the scope of use
`ifndef SORTED_PRIORITY_QUEUE_TOP_ASSERT_SVH
`define SORTED_PRIORITY_QUEUE_TOP_ASSERT_SVH

// same-cycle implication, disabled during reset
`define SPQ_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("sorted priority queue check failed");

// next-cycle implication, disabled during reset
`define SPQ_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("sorted priority queue check failed");

`endif

// ----- hw/rtl/spq_pkg.sv -----
// shared types and constants for the sorted priority queue
// no dependencies
`default_nettype none

package spq_pkg;

    localparam int CAPACITY = 16;
    localparam int CNT_W    = $clog2(CAPACITY + 1);

    localparam logic FUNC_INSERT = 1'b0;
    localparam logic FUNC_REMOVE = 1'b1;

    localparam logic [1:0] STATUS_DONE  = 2'd0;
    localparam logic [1:0] STATUS_EMPTY = 2'd1;
    localparam logic [1:0] STATUS_FULL  = 2'd2;

    typedef struct packed {
        logic               func;
        logic signed [31:0] item_value;
        logic signed [15:0] item_priority;
    } in_req_t;

    typedef struct packed {
        logic [1:0]         status;
        logic signed [31:0] out_value;
        logic signed [15:0] out_priority;
        logic [4:0]         fill_count;
    } out_req_t;

    typedef struct packed {
        logic signed [31:0] value;
        logic signed [15:0] prio;
    } entry_t;

    typedef struct packed {
        logic ins;
        logic rem;
    } cell_ctrl_t;

endpackage

`default_nettype wire

// ----- hw/rtl/spq_cell.sv -----
// one storage cell of the sorted chain
// depends on spq_pkg
`default_nettype none

module spq_cell
    import spq_pkg::*;
(
    input  wire logic       clk,
    input  wire cell_ctrl_t ctrl,
    input  wire logic       occupied,
    input  wire entry_t     new_entry,
    input  wire entry_t     prev_entry,
    input  wire logic       prev_greater,
    input  wire entry_t     next_entry,
    output logic            greater,
    output entry_t          entry
);

    entry_t entry_reg;
    entry_t entry_next;

    // empty cells count as greater so the flags stay monotone along the chain
    assign greater = !occupied || (entry_reg.prio > new_entry.prio);
    assign entry   = entry_reg;

    always_comb
    begin
        entry_next = entry_reg;
        priority if (ctrl.ins && greater && !prev_greater)
        begin
            entry_next = new_entry;
        end
        else if (ctrl.ins && greater)
        begin
            entry_next = prev_entry;
        end
        else if (ctrl.rem)
        begin
            entry_next = next_entry;
        end
        else
        begin
            entry_next = entry_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

endmodule

`default_nettype wire

// ----- hw/rtl/sorted_priority_queue_top.sv -----
// top level of the sorted priority queue: cell chain, count and result register
// depends on spq_pkg, spq_cell and sorted_priority_queue_top_assert.svh
//
// usage
//   in channel  (in_valid / in_ready / in_data): one request per operation,
//     func selects insert or remove; value and priority are ignored on remove
//   out channel (out_valid / out_ready / out_data): exactly one result request
//     per accepted input, in order: status, removed value and priority (zero
//     unless a remove succeeded) and the fill count after the operation
//   timing: the result is registered and valid in the cycle after the input is accepted
//   throughput: one operation per cycle while no result waits on out_ready; every cell
//     compares its priority with the incoming one and all cells shift together
//   stall: a new request is taken whenever the result register is empty or is
//     being emptied in the same cycle; while out_ready stays low with a result
//     waiting, in_ready is low and the queue holds still
//   reset: rst_n is asynchronous and active low; it empties the queue and the
//     result register; the cell contents need no reset since only cells below
//     the count are ever read
//   full store: an insert is refused with a full status and changes nothing;
//     a remove on an empty queue returns an empty status
`default_nettype none

module sorted_priority_queue_top
    import spq_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    in_valid,
    output logic         in_ready,
    input  wire in_req_t in_data,
    output logic         out_valid,
    input  wire logic    out_ready,
    output out_req_t     out_data
);

`include "sorted_priority_queue_top_assert.svh"

    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             out_valid_reg;
    logic             out_valid_next;
    out_req_t         out_data_reg;
    out_req_t         out_data_next;

    logic       accept;
    logic       is_full;
    logic       is_empty;
    cell_ctrl_t ctrl;

    entry_t     new_entry;
    entry_t     cell_entry [CAPACITY];
    logic       cell_greater [CAPACITY];

    // the result register parts the two sides: take a request when it drains
    assign in_ready = !out_valid_reg || out_ready;
    assign accept   = in_valid && in_ready;

    assign is_full  = (count_reg == CNT_W'(CAPACITY));
    assign is_empty = (count_reg == '0);

    assign ctrl.ins = accept && (in_data.func == FUNC_INSERT) && !is_full;
    assign ctrl.rem = accept && (in_data.func == FUNC_REMOVE) && !is_empty;

    assign new_entry.value = in_data.item_value;
    assign new_entry.prio  = in_data.item_priority;

    // chain of cells, head at index zero
    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        localparam logic [CNT_W-1:0] IDX = CNT_W'(i);

        logic   occupied;
        entry_t prev_entry;
        logic   prev_greater;
        entry_t next_entry;

        assign occupied = (IDX < count_reg);

        if (i == 0)
        begin : g_head
            // the head has no neighbour in front, so it takes a new entry first
            assign prev_entry   = new_entry;
            assign prev_greater = 1'b0;
        end
        else
        begin : g_body
            assign prev_entry   = cell_entry[i-1];
            assign prev_greater = cell_greater[i-1];
        end

        if (i == CAPACITY - 1)
        begin : g_tail
            // the tail slot goes empty on a remove, its contents no longer matter
            assign next_entry = cell_entry[i];
        end
        else
        begin : g_inner
            assign next_entry = cell_entry[i+1];
        end

        spq_cell u_cell (
            .clk          (clk),
            .ctrl         (ctrl),
            .occupied     (occupied),
            .new_entry    (new_entry),
            .prev_entry   (prev_entry),
            .prev_greater (prev_greater),
            .next_entry   (next_entry),
            .greater      (cell_greater[i]),
            .entry        (cell_entry[i])
        );
    end

    // count update and result formation
    always_comb
    begin
        count_next     = count_reg;
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;

        if (out_ready)
        begin
            out_valid_next = 1'b0;
        end

        if (ctrl.ins)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (ctrl.rem)
        begin
            count_next = count_reg - CNT_W'(1);
        end

        if (accept)
        begin
            out_valid_next             = 1'b1;
            out_data_next.status       = STATUS_DONE;
            out_data_next.out_value    = '0;
            out_data_next.out_priority = '0;
            out_data_next.fill_count   = 5'(count_next);
            if (in_data.func == FUNC_INSERT)
            begin
                if (is_full)
                begin
                    out_data_next.status = STATUS_FULL;
                end
            end
            else if (is_empty)
            begin
                out_data_next.status = STATUS_EMPTY;
            end
            else
            begin
                out_data_next.out_value    = cell_entry[0].value;
                out_data_next.out_priority = cell_entry[0].prio;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // result payload carries no reset
    always_ff @(posedge clk)
    begin
        out_data_reg <= out_data_next;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    // checks
    `SPQ_ASSERT_IMPL(a_count_bound, 1'b1, count_reg <= CNT_W'(CAPACITY))
    `SPQ_ASSERT_NEXT(a_insert_grows, ctrl.ins, count_reg == $past(count_reg) + CNT_W'(1))
    `SPQ_ASSERT_IMPL(a_fill_matches, out_valid_reg, out_data_reg.fill_count == 5'(count_reg))
    `SPQ_ASSERT_IMPL(a_head_sorted, count_reg >= CNT_W'(2),
        cell_entry[0].prio <= cell_entry[1].prio)

endmodule

`default_nettype wire

// ----- dv/tb_sorted_priority_queue_top.sv -----
// self-checking testbench for sorted_priority_queue_top: directed table, then random traffic
// depends on spq_pkg and sorted_priority_queue_top; predicts every result with a local model
`timescale 1ns / 1ps

module tb_sorted_priority_queue_top;
    import spq_pkg::*;

    localparam int DIRECTED_ROWS = 20;
    localparam int RANDOM_ITEMS  = 1430;
    // final stretch with both sides running flat out
    localparam int TAIL_ITEMS    = 200;

    // one row of the directed table; want is only used when known is set
    typedef struct packed {
        logic     known;
        in_req_t  req;
        out_req_t want;
    } directed_row_t;

    localparam out_req_t FROM_MODEL = '0;

    logic     clk = 1'b0;
    logic     rst_n;
    logic     in_valid;
    logic     in_ready;
    in_req_t  in_data;
    logic     out_valid;
    logic     out_ready;
    out_req_t out_data;

    // local copy of the sorted store, head at index 0
    logic signed [31:0] held_values [$];
    logic signed [15:0] held_prios [$];

    // results still owed by the block, oldest first
    out_req_t      pending_results [$];
    out_req_t      oldest_expected;
    int            mismatch_count = 0;
    logic          quiet_tail = 1'b0;
    directed_row_t directed_rows [DIRECTED_ROWS];

    sorted_priority_queue_top dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // apply one operation to the local store and return the result it should give
    function automatic out_req_t predict_queue_op(input in_req_t req);
        out_req_t res;
        int       slot;
        res = '0;
        res.status = STATUS_DONE;
        if (req.func == FUNC_INSERT)
        begin
            if (held_prios.size() >= CAPACITY)
                res.status = STATUS_FULL;
            else
            begin
                // new entry goes behind every entry of lower or equal priority number
                slot = 0;
                while (slot < held_prios.size() && held_prios[slot] <= req.item_priority)
                    slot++;
                held_prios.insert(slot, req.item_priority);
                held_values.insert(slot, req.item_value);
            end
        end
        else
        begin
            if (held_prios.size() == 0)
                res.status = STATUS_EMPTY;
            else
            begin
                res.out_value    = held_values.pop_front();
                res.out_priority = held_prios.pop_front();
            end
        end
        res.fill_count = 5'(held_prios.size());
        return res;
    endfunction

    // present one request, hold it until taken, then outside the quiet tail sometimes drop in_valid
    task automatic send_request(input in_req_t req, input logic known, input out_req_t want);
        out_req_t predicted;
        in_valid <= 1'b1;
        in_data  <= req;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        // taken at this edge: the model advances in step with the block
        predicted = predict_queue_op(req);
        pending_results.push_back(known ? want : predicted);
        if (!quiet_tail && $urandom_range(0, 2) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
    endtask

    // hold off the sender until the block has handed back every result
    task automatic drain_results();
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (pending_results.size() != 0);
    endtask

    task automatic check_field(input string name, input logic signed [31:0] want,
                               input logic signed [31:0] got);
        if (got !== want)
        begin
            mismatch_count++;
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
        end
    endtask

    // result side: every request taken is checked against the oldest expectation
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_results.size() == 0)
            begin
                mismatch_count++;
                $display("%0t: unexpected result, expected none, actual %h", $time, out_data);
            end
            else
            begin
                oldest_expected = pending_results.pop_front();
                check_field("status", oldest_expected.status, out_data.status);
                check_field("out_value", oldest_expected.out_value, out_data.out_value);
                check_field("out_priority", oldest_expected.out_priority,
                            out_data.out_priority);
                check_field("fill_count", oldest_expected.fill_count, out_data.fill_count);
            end
        end
    end

    // result side back-pressure: runs of readiness, short or long, broken by idle gaps outside the quiet tail
    initial
    begin
        out_ready = 1'b0;
        @(posedge rst_n);
        @(posedge clk);
        forever
        begin
            out_ready <= 1'b1;
            if ($urandom_range(0, 4) == 0)
                repeat ($urandom_range(20, 60)) @(posedge clk);
            else
                repeat ($urandom_range(1, 8)) @(posedge clk);
            if (!quiet_tail)
            begin
                out_ready <= 1'b0;
                repeat ($urandom_range(1, 4)) @(posedge clk);
            end
        end
    end

    // request side: reset, directed table, random traffic, then wind down
    initial
    begin
        in_req_t req;
        int      insert_pct;
        int      pick;

        rst_n    = 1'b0;
        in_valid = 1'b0;
        in_data  = '0;
        insert_pct = 50;

        directed_rows = '{
            // remove straight after reset finds nothing
            '{1'b1, '{FUNC_REMOVE, 32'sd0, 16'sd0}, '{STATUS_EMPTY, 32'sd0, 16'sd0, 5'd0}},
            // extremes of value and priority
            '{1'b1, '{FUNC_INSERT, 32'sh7FFF_FFFF, 16'sh7FFF},
                    '{STATUS_DONE, 32'sd0, 16'sd0, 5'd1}},
            '{1'b1, '{FUNC_INSERT, 32'sh8000_0000, 16'sh8000},
                    '{STATUS_DONE, 32'sd0, 16'sd0, 5'd2}},
            '{1'b1, '{FUNC_INSERT, -32'sd1, 16'sd0}, '{STATUS_DONE, 32'sd0, 16'sd0, 5'd3}},
            // same priority again: must leave after the one above
            '{1'b1, '{FUNC_INSERT, 32'sd0, 16'sd0}, '{STATUS_DONE, 32'sd0, 16'sd0, 5'd4}},
            // fill the rest of the store with mixed priorities and ties
            '{1'b0, '{FUNC_INSERT, 32'sh0000_0101, 16'sd5}, FROM_MODEL},
            '{1'b0, '{FUNC_INSERT, 32'sh0000_0202, -16'sd3}, FROM_MODEL},
            '{1'b0, '{FUNC_INSERT, 32'sh0000_0303, 16'sd5}, FROM_MODEL},
            '{1'b0, '{FUNC_INSERT, 32'sh5555_5555, 16'sd100}, FROM_MODEL},
            '{1'b0, '{FUNC_INSERT, 32'shAAAA_AAAA, 16'sh8000}, FROM_MODEL},
            '{1'b0, '{FUNC_INSERT, 32'sh0000_0606, 16'sd0}, FROM_MODEL},
            '{1'b0, '{FUNC_INSERT, 32'sh0000_0707, 16'sd7}, FROM_MODEL},
            '{1'b0, '{FUNC_INSERT, 32'sh0000_0808, -16'sd3}, FROM_MODEL},
            '{1'b0, '{FUNC_INSERT, 32'sh0F0F_0F0F, 16'sh7FFF}, FROM_MODEL},
            '{1'b0, '{FUNC_INSERT, 32'sh0000_0A0A, 16'sd1}, FROM_MODEL},
            '{1'b0, '{FUNC_INSERT, 32'sh0000_0B0B, 16'sd2}, FROM_MODEL},
            '{1'b0, '{FUNC_INSERT, 32'shF0F0_F0F0, -16'sd1}, FROM_MODEL},
            // store now full: insert is refused and nothing moves
            '{1'b1, '{FUNC_INSERT, 32'sh1234_5678, 16'sd0},
                    '{STATUS_FULL, 32'sd0, 16'sd0, 5'd16}},
            // head is the first of the two lowest-priority entries
            '{1'b1, '{FUNC_REMOVE, 32'sd0, 16'sd0},
                    '{STATUS_DONE, 32'sh8000_0000, 16'sh8000, 5'd15}},
            '{1'b0, '{FUNC_REMOVE, 32'sh7FFF_FFFF, 16'sh7FFF}, FROM_MODEL}
        };

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[r])
            send_request(directed_rows[r].req, directed_rows[r].known, directed_rows[r].want);

        // let the directed part settle before random traffic starts
        drain_results();

        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            // phases biased to fill up, hover, or drain, so full and empty both come round
            if (n % 48 == 0)
            begin
                case ($urandom_range(0, 2))
                    0:       insert_pct = 85;
                    1:       insert_pct = 50;
                    default: insert_pct = 15;
                endcase
            end
            if (n == RANDOM_ITEMS / 2)
                drain_results();
            if (n == RANDOM_ITEMS - TAIL_ITEMS)
                quiet_tail = 1'b1;

            req.func = ($urandom_range(0, 99) < insert_pct) ? FUNC_INSERT : FUNC_REMOVE;

            pick = $urandom_range(0, 15);
            if (pick == 0)
                req.item_value = 32'sh8000_0000;
            else if (pick == 1)
                req.item_value = 32'sh7FFF_FFFF;
            else
                req.item_value = $urandom;

            // half the time a narrow band, so that ties are common
            case ($urandom_range(0, 9))
                0, 1, 2, 3, 4: req.item_priority = 16'($urandom_range(0, 8)) - 16'sd4;
                5, 6, 7:       req.item_priority = 16'($urandom);
                8:             req.item_priority = 16'sh8000;
                default:       req.item_priority = 16'sh7FFF;
            endcase

            send_request(req, 1'b0, FROM_MODEL);
        end

        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (pending_results.size() != 0);
        // keep the clock running so a stray extra result would still be caught
        repeat (4) @(posedge clk);

        if (mismatch_count == 0)
            $display("tb_sorted_priority_queue_top: done, clean");
        else
            $display("tb_sorted_priority_queue_top: done, errors");
        $finish;
    end

    // watchdog: 2 ms is many times the slowest legal run
    initial
    begin
        #2_000_000;
        $display("tb_sorted_priority_queue_top: done, errors");
        $finish;
    end

endmodule
